/* hdl/morton_hash_bucket_histogram_defines.svh */
// Assertion macros for the histogram modules; mhbh_ctrl uses them.
// Depends on nothing; a module that uses them has signals named clk and arst_n.
`ifndef MORTON_HASH_BUCKET_HISTOGRAM_DEFINES_SVH
`define MORTON_HASH_BUCKET_HISTOGRAM_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MHBH_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MHBH_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/mhbh_pkg.sv */
// Shared types, constants and the Morton interleave function of the histogram.
// Depends on nothing.
package mhbh_pkg;

	localparam int TABLE_BITS_DEF  = 10;
	localparam int COORD_BITS_DEF  = 16;
	localparam int COUNT_WIDTH_DEF = 32;

	localparam int KEY_W       = 16;
	localparam int MORTON_W    = 3 * KEY_W;
	localparam int BUCKET_W    = 10;
	localparam int OUT_COUNT_W = 32;
	localparam int IN_DATA_W   = 3 * KEY_W;
	localparam int OUT_USED_W  = BUCKET_W + 2 * OUT_COUNT_W;
	localparam int OUT_DATA_W  = ((OUT_USED_W + 7) / 8) * 8;
	localparam int OUT_PAD_W   = OUT_DATA_W - OUT_USED_W;
	localparam int WIDE_COUNT_W  = 64;
	localparam int WIDE_BUCKET_W = 16;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;     // item taken: latch it and read its bucket
		logic clr_max;    // clear item taken: zero the maximum
		logic clr_step;   // write zero to the next entry of the sweep
		logic upd;        // write the incremented count and load the result
		logic clr_out;    // load the result of a clear
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clr_last;   // the sweep stands at the final entry
	} sts_t;

	// Interleaves the low coord_bits of each coordinate, x highest in each triple.
	function automatic logic [MORTON_W-1:0] morton_code(
		input logic [KEY_W-1:0] x,
		input logic [KEY_W-1:0] y,
		input logic [KEY_W-1:0] z,
		input int unsigned      coord_bits
	);
		logic [MORTON_W-1:0] code;
		code = '0;
		for (int i = 0; i < KEY_W; i++) begin
			if (i < coord_bits) begin
				code[3*i+2] = x[i];
				code[3*i+1] = y[i];
				code[3*i]   = z[i];
			end
		end
		return code;
	endfunction

endpackage

/* hdl/mhbh_ctrl.sv */
// Controller of the histogram: sequences counting, clearing sweeps and results.
// Depends on mhbh_pkg and morton_hash_bucket_histogram_defines.svh.
`include "morton_hash_bucket_histogram_defines.svh"

module mhbh_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	input  logic          s_tuser,
	output logic          s_tready,
	input  logic          m_tready,
	output logic          m_tvalid,
	output mhbh_pkg::cmd_t cmd,
	input  mhbh_pkg::sts_t sts
);
	import mhbh_pkg::*;

	localparam logic [1:0] ST_CLEAR   = 2'd0;
	localparam logic [1:0] ST_IDLE    = 2'd1;
	localparam logic [1:0] ST_UPDATE  = 2'd2;
	localparam logic [1:0] ST_CLRDONE = 2'd3;

	logic [1:0] state_q, state_d;
	logic       send_q, send_d;
	logic       out_valid_q;
	logic       out_free;
	logic       accept;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;
	assign m_tvalid = out_valid_q;

	always_comb begin
		state_d      = state_q;
		send_d       = send_q;
		cmd          = '0;
		cmd.accept   = accept;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (s_tuser) begin
						cmd.clr_max = 1'b1;
						send_d      = 1'b1;
						state_d     = ST_CLEAR;
					end else begin
						state_d = ST_UPDATE;
					end
				end
			end
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					state_d = send_q ? ST_CLRDONE : ST_IDLE;
				end
			end
			ST_UPDATE: begin
				if (out_free) begin
					cmd.upd = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_CLRDONE: begin
				if (out_free) begin
					cmd.clr_out = 1'b1;
					send_d      = 1'b0;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			send_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			send_q  <= send_d;
			if (cmd.upd || cmd.clr_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`MHBH_ASSERT_IMPL(a_no_overwrite, cmd.upd || cmd.clr_out, out_free, "result overwritten")
	`MHBH_ASSERT_NEXT(a_sweep_runs, state_q == ST_CLEAR && !sts.clr_last, state_q == ST_CLEAR, "sweep cut short")
	`MHBH_ASSERT_NEXT(a_one_at_a_time, accept, !s_tready, "item taken while busy")
	`MHBH_ASSERT_IMPL(a_one_write, 1'b1, $onehot0({cmd.upd, cmd.clr_out, cmd.clr_step}), "commands collide")

endmodule

/* hdl/mhbh_datapath.sv */
// Datapath of the histogram: Morton hash, counter memory, maximum and result register.
// Depends on mhbh_pkg; driven by commands from mhbh_ctrl.
module mhbh_datapath #(
	parameter int TABLE_BITS  = mhbh_pkg::TABLE_BITS_DEF,
	parameter int COORD_BITS  = mhbh_pkg::COORD_BITS_DEF,
	parameter int COUNT_WIDTH = mhbh_pkg::COUNT_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [mhbh_pkg::IN_DATA_W-1:0]  s_tdata,
	input  logic                            s_tlast,
	output logic [mhbh_pkg::OUT_DATA_W-1:0] m_tdata,
	output logic                            m_tlast,
	input  mhbh_pkg::cmd_t                  cmd,
	output mhbh_pkg::sts_t                  sts
);
	import mhbh_pkg::*;

	localparam int DEPTH = 1 << TABLE_BITS;

	logic [COUNT_WIDTH-1:0] mem [DEPTH];

	logic [MORTON_W-1:0]    code;
	logic [TABLE_BITS-1:0]  raddr;
	logic [TABLE_BITS-1:0]  bucket_q;
	logic                   last_q;
	logic [COUNT_WIDTH-1:0] rdata_q;
	logic [COUNT_WIDTH-1:0] max_q;
	logic [TABLE_BITS-1:0]  clr_addr_q;
	logic [COUNT_WIDTH-1:0] cnext;
	logic [COUNT_WIDTH-1:0] max_next;
	logic                   we;
	logic [TABLE_BITS-1:0]  waddr;
	logic [COUNT_WIDTH-1:0] wdata;
	logic [WIDE_COUNT_W-1:0]  cnext_w;
	logic [WIDE_COUNT_W-1:0]  max_w;
	logic [WIDE_BUCKET_W-1:0] bucket_w;

	logic [BUCKET_W-1:0]    out_bucket_q;
	logic [OUT_COUNT_W-1:0] out_count_q;
	logic [OUT_COUNT_W-1:0] out_max_q;
	logic                   out_last_q;

	assign code  = morton_code(s_tdata[KEY_W-1:0], s_tdata[2*KEY_W-1:KEY_W],
		s_tdata[3*KEY_W-1:2*KEY_W], COORD_BITS);
	assign raddr = code[TABLE_BITS-1:0];

	// The counter saturates at all ones.
	assign cnext    = (&rdata_q) ? rdata_q : rdata_q + COUNT_WIDTH'(1);
	assign max_next = (cnext > max_q) ? cnext : max_q;

	assign we    = cmd.clr_step || cmd.upd;
	assign waddr = cmd.clr_step ? clr_addr_q : bucket_q;
	assign wdata = cmd.clr_step ? '0 : cnext;

	assign cnext_w  = WIDE_COUNT_W'(cnext);
	assign max_w    = WIDE_COUNT_W'(max_next);
	assign bucket_w = WIDE_BUCKET_W'(bucket_q);

	assign sts.clr_last = &clr_addr_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (cmd.accept) begin
			rdata_q  <= mem[raddr];
			bucket_q <= raddr;
			last_q   <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q      <= '0;
			clr_addr_q <= '0;
		end else begin
			if (cmd.clr_max) begin
				max_q <= '0;
			end else if (cmd.upd) begin
				max_q <= max_next;
			end
			if (cmd.clr_step) begin
				clr_addr_q <= clr_addr_q + TABLE_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.upd) begin
			out_bucket_q <= bucket_w[BUCKET_W-1:0];
			out_count_q  <= cnext_w[OUT_COUNT_W-1:0];
			out_max_q    <= max_w[OUT_COUNT_W-1:0];
			out_last_q   <= last_q;
		end else if (cmd.clr_out) begin
			out_bucket_q <= '0;
			out_count_q  <= '0;
			out_max_q    <= '0;
			out_last_q   <= last_q;
		end
	end

	assign m_tdata = {{OUT_PAD_W{1'b0}}, out_max_q, out_count_q, out_bucket_q};
	assign m_tlast = out_last_q;

endmodule

/* hdl/morton_hash_bucket_histogram.sv */
// Morton hash bucket histogram, top level: joins mhbh_ctrl and mhbh_datapath (uses mhbh_pkg).
// A counted item is accepted only when idle; its result loads once the result register is free.
// A clear item sweeps the counter memory one entry a cycle, then loads a zeroed result.
// After reset the same sweep runs with s_tready low and no result.
// The result register lets the next item be accepted while a result waits to be taken.
// Reset is asynchronous, active low, and clears the control state, the sweep address and the maximum.
module morton_hash_bucket_histogram #(
	parameter int TABLE_BITS  = mhbh_pkg::TABLE_BITS_DEF,
	parameter int COORD_BITS  = mhbh_pkg::COORD_BITS_DEF,
	parameter int COUNT_WIDTH = mhbh_pkg::COUNT_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// Input items.
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [mhbh_pkg::IN_DATA_W-1:0]  s_tdata,  // key_x, key_y, key_z from bit 0 up
	input  logic                            s_tuser,  // func: 1 clears all counters
	input  logic                            s_tlast,  // last_key
	// Result items.
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [mhbh_pkg::OUT_DATA_W-1:0] m_tdata,  // bucket, bucket_count, max_count, zeros
	output logic                            m_tlast   // run_end
);
	import mhbh_pkg::*;

	// The controller and datapath talk only through these two structs.
	cmd_t cmd;
	sts_t sts;

	// The controller owns the handshakes and the state sequence: idle, update,
	// clearing sweep and the result of a clear.
	mhbh_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tuser  (s_tuser),
		.s_tready (s_tready),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.cmd      (cmd),
		.sts      (sts)
	);

	// The datapath hashes the key as it is accepted and reads its counter in the
	// same edge; the update state then writes the saturated increment back and loads the
	// result register, so a following item never sees a stale counter.
	mhbh_datapath #(
		.TABLE_BITS  (TABLE_BITS),
		.COORD_BITS  (COORD_BITS),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tdata (s_tdata),
		.s_tlast (s_tlast),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast),
		.cmd     (cmd),
		.sts     (sts)
	);

endmodule
